@@ sv/mlp_pkg.sv @@
// Shared types and constants of the min-max linear partition block.
package mlp_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_LOOP,
		ST_DRAIN,
		ST_BT,
		ST_BT_WAIT,
		ST_EMIT
	} state_t;

	localparam logic       REG_NUM_STAGES   = 1'b0;
	localparam logic [4:0] NUM_STAGES_RESET = 5'd1;

endpackage

@@ sv/mlp_ram.sv @@
// Simple dual-port synchronous RAM with a registered read.
module mlp_ram #(
	parameter int W  = 8,
	parameter int D  = 16,
	parameter int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/mlp_cfg.sv @@
// APB register file holding the stage count.
module mlp_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [4:0]  num_stages
);
	import mlp_pkg::*;

	logic [4:0] num_stages_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_stages_q <= NUM_STAGES_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_NUM_STAGES) begin
			num_stages_q <= pwdata[4:0];
		end
	end

	assign pready     = 1'b1;
	assign prdata     = (paddr[2] == REG_NUM_STAGES) ? {27'd0, num_stages_q} : 32'd0;
	assign num_stages = num_stages_q;

endmodule

@@ sv/minmax_linear_partition_dp.sv @@
// Top level: block intake, min-max partition table walk, backtrack and stage results.
//
// Blocks are accepted one per cycle while busy is low; up to MAX_BLOCKS per sequence each write
// one prefix-sum entry. The block marked last_block raises busy and starts the table walk
// unless an error is found; the walk runs on the single read port of the cost-table memory
// and visits every cell (m, p) with p <= min(m, S) for N blocks and S stages, followed by the
// backtrack and the stage results. Results come one per cycle on result_valid and cannot be
// held off; an error result comes alone, in the cycle after the last block, and busy stays
// low for it.
module minmax_linear_partition_dp #(
	parameter int MAX_BLOCKS = 256,
	parameter int MAX_STAGES = 16,
	parameter int TIME_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] forward_cost,
	input  logic [31:0] backward_cost,
	input  logic        last_block,
	output logic        result_valid,
	output logic [3:0]  stage_number,
	output logic [7:0]  first_block,
	output logic [40:0] bottleneck_cost,
	output logic        last_stage,
	output logic        error_flag
);
	import mlp_pkg::*;

	localparam int MW     = $clog2(MAX_BLOCKS + 1);
	localparam int PW     = $clog2(MAX_STAGES + 1);
	localparam int SIW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
	localparam int CW     = TIME_WIDTH + MW + 2;
	localparam int CDW    = CW + MW;
	localparam int STRIDE = MAX_STAGES + 1;
	localparam int CDEPTH = (MAX_BLOCKS + 1) * STRIDE;
	localparam int CAW    = $clog2(CDEPTH);
	localparam logic [31:0] TMASK = 32'((64'd1 << TIME_WIDTH) - 64'd1);
	localparam logic [CW-1:0] INF = '1;

	function automatic logic [CAW-1:0] cell_addr(input logic [MW-1:0] m,
		input logic [PW-1:0] p);
		return CAW'(int'(m) * STRIDE + int'(p));
	endfunction

	logic [4:0] num_stages;

	mlp_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.num_stages(num_stages)
	);

	state_t state_q, state_d;

	logic [MW-1:0]  bc_q, n_q, m_q, r_q, r_s1, r_s2, arg_q;
	logic [PW-1:0]  s_q, p_q, k_q;
	logic [CW-1:0]  sum_q, pm_q, best_q, c_s2, bott_q;
	logic           ovf_q, first_q, v_s1, v_s2, inf_s1, zc_s1, zp_s1;
	logic [MW-1:0]  split_q [MAX_STAGES];

	logic           res_v_q, res_last_q, res_err_q;
	logic [3:0]     res_stage_q;
	logic [7:0]     res_first_q;
	logic [CW-1:0]  res_cost_q;

	logic           acc, p_we, c_we, err_now, row_more, col_more;
	logic [CW-1:0]  cost_in, prd, cell_val, pr, diff;
	logic [MW-1:0]  p_waddr, p_raddr, n_next;
	logic [CAW-1:0] c_waddr, c_raddr;
	logic [CDW-1:0] crd;
	logic [PW-1:0]  pm1;
	logic           ovf_next;

	mlp_ram #(.W(CW), .D(MAX_BLOCKS + 1)) u_prefix (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(sum_q + cost_in),
		.raddr(p_raddr), .rdata(prd)
	);

	mlp_ram #(.W(CDW), .D(CDEPTH)) u_cost (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata({arg_q, best_q}),
		.raddr(c_raddr), .rdata(crd)
	);

	assign busy     = (state_q != ST_IDLE);
	assign acc      = start && !busy;
	assign cost_in  = CW'(forward_cost & TMASK) + CW'(backward_cost & TMASK);
	assign p_we     = acc && (int'(bc_q) < MAX_BLOCKS);
	assign p_waddr  = bc_q + MW'(1);
	assign n_next   = p_we ? bc_q + MW'(1) : bc_q;
	assign ovf_next = ovf_q || !p_we;
	assign err_now  = ovf_next || num_stages == 5'd0 || int'(num_stages) > MAX_STAGES
		|| int'(num_stages) > int'(n_next);
	assign pm1      = p_q - PW'(1);
	assign col_more = (int'(p_q) < int'(m_q)) && (p_q < s_q);
	assign row_more = m_q < n_q;
	assign c_waddr  = cell_addr(m_q, p_q);

	always_comb begin
		state_d = state_q;
		p_raddr = m_q;
		c_raddr = cell_addr(r_q, pm1);
		c_we    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (acc && last_block && !err_now) begin
					state_d = ST_ROW;
				end
			end
			ST_ROW: begin
				state_d = ST_LOOP;
			end
			ST_LOOP: begin
				p_raddr = r_q;
				if (r_q == m_q - MW'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					c_we    = 1'b1;
					state_d = (col_more || row_more) ? ST_ROW : ST_BT;
				end
			end
			ST_BT: begin
				c_raddr = cell_addr(m_q, p_q);
				state_d = ST_BT_WAIT;
			end
			ST_BT_WAIT: begin
				state_d = (p_q == PW'(1)) ? ST_EMIT : ST_BT;
			end
			ST_EMIT: begin
				if (k_q == s_q - PW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Cells with more stages than blocks, and column zero past row zero, are infinite.
	assign cell_val = zc_s1 ? '0 : (inf_s1 ? INF : crd[CW-1:0]);
	assign pr       = zp_s1 ? '0 : prd;
	assign diff     = pm_q - pr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q    <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			res_v_q <= (acc && last_block && err_now) || (state_q == ST_EMIT);
			v_s1    <= (state_q == ST_LOOP);
			v_s2    <= v_s1;
			if (acc) begin
				if (last_block) begin
					bc_q  <= '0;
					sum_q <= '0;
					ovf_q <= 1'b0;
				end else if (p_we) begin
					bc_q  <= bc_q + MW'(1);
					sum_q <= sum_q + cost_in;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && last_block) begin
			n_q         <= n_next;
			s_q         <= PW'(num_stages);
			m_q         <= MW'(1);
			p_q         <= PW'(1);
			res_stage_q <= 4'd0;
			res_first_q <= 8'd0;
			res_cost_q  <= '0;
			res_last_q  <= 1'b1;
			res_err_q   <= 1'b1;
		end
		case (state_q)
			ST_ROW: begin
				r_q     <= '0;
				best_q  <= INF;
				arg_q   <= '0;
				first_q <= 1'b1;
			end
			ST_LOOP: begin
				first_q <= 1'b0;
				if (first_q) begin
					pm_q <= prd;
				end
				r_s1   <= r_q;
				zc_s1  <= (pm1 == '0) && (r_q == '0);
				inf_s1 <= ((pm1 == '0) && (r_q != '0)) || (int'(pm1) > int'(r_q));
				zp_s1  <= (r_q == '0);
				r_q    <= r_q + MW'(1);
			end
			ST_DRAIN: begin
				if (!v_s1 && !v_s2) begin
					if (col_more) begin
						p_q <= p_q + PW'(1);
					end else if (row_more) begin
						m_q <= m_q + MW'(1);
						p_q <= PW'(1);
					end else begin
						m_q <= n_q;
						p_q <= s_q;
					end
				end
			end
			ST_BT_WAIT: begin
				if (p_q == s_q) begin
					bott_q <= crd[CW-1:0];
				end
				split_q[SIW'(pm1)] <= crd[CDW-1:CW];
				m_q                <= crd[CDW-1:CW];
				p_q                <= pm1;
				k_q                <= '0;
			end
			ST_EMIT: begin
				res_stage_q <= 4'(k_q);
				res_first_q <= 8'(split_q[SIW'(k_q)]);
				res_cost_q  <= bott_q;
				res_last_q  <= (k_q == s_q - PW'(1));
				res_err_q   <= 1'b0;
				k_q         <= k_q + PW'(1);
			end
			default: begin
			end
		endcase
		if (v_s1) begin
			c_s2 <= (cell_val > diff) ? cell_val : diff;
			r_s2 <= r_s1;
		end
		// Strict compare keeps the earliest split point among equal costs.
		if (v_s2 && c_s2 < best_q) begin
			best_q <= c_s2;
			arg_q  <= r_s2;
		end
	end

	assign result_valid    = res_v_q;
	assign stage_number    = res_stage_q;
	assign first_block     = res_first_q;
	assign bottleneck_cost = 41'(res_cost_q);
	assign last_stage      = res_last_q;
	assign error_flag      = res_err_q;

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && error_flag |-> last_stage)
		else $error("error beat without last_stage");

	a_stage_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_stage |=> result_valid
			&& stage_number == $past(stage_number) + 4'd1)
		else $error("stage beats not consecutive");

	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_stage |-> busy)
		else $error("busy dropped while stages remain");

endmodule

@@ tb/minmax_linear_partition_dp_tb.sv @@
// Self-checking testbench of the min-max linear partition block: directed table, then random sequences.
module minmax_linear_partition_dp_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mlp_pkg::*;

	localparam int NBLK = 256;
	localparam int NSTG = 16;
	localparam int WATCH_LIMIT = 300000;
	localparam logic [63:0] COST_INF = '1;

	typedef struct packed {
		logic [3:0]  stage;
		logic [7:0]  first;
		logic [40:0] cost;
		logic        last;
		logic        err;
	} stage_res_t;

	typedef struct {
		int         cfg;	// -1 keeps the current stage count
		logic [31:0] fwd;
		logic [31:0] bwd;
		logic       fin;
		bit         typed;
		stage_res_t res;
	} dir_row_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic start, busy;
	logic [31:0] forward_cost, backward_cost;
	logic last_block;
	logic result_valid;
	logic [3:0] stage_number;
	logic [7:0] first_block;
	logic [40:0] bottleneck_cost;
	logic last_stage, error_flag;

	minmax_linear_partition_dp u_dut (.*);

	// Predictor state.
	logic [63:0] run_sum [0:NBLK];
	logic [63:0] minmax_tbl [0:NBLK][0:NSTG];
	int unsigned split_at [0:NSTG-1];
	int unsigned blocks_held;
	bit          dropped_block;
	int unsigned stage_cfg;

	stage_res_t stage_q[$];
	int mismatches;
	int idle_cycles;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] max64(logic [63:0] a, logic [63:0] b);
		return a > b ? a : b;
	endfunction

	// Takes one block; returns the stage results it causes.
	function automatic void partition_block(logic [31:0] fwd, logic [31:0] bwd, logic fin,
			ref stage_res_t outs[$]);
		int unsigned n, s, m, p, r, top;
		logic [63:0] best, c, target;
		stage_res_t e;
		outs = {};
		if (blocks_held < NBLK) begin
			run_sum[blocks_held + 1] = run_sum[blocks_held] + {32'd0, fwd} + {32'd0, bwd};
			blocks_held++;
		end else begin
			dropped_block = 1;
		end
		if (!fin)
			return;
		n = blocks_held;
		s = stage_cfg;
		if (dropped_block || s == 0 || s > NSTG || s > n) begin
			e = '{stage: 0, first: 0, cost: 0, last: 1, err: 1};
			outs.insert(outs.size(), e);
		end else begin
			for (m = 0; m <= n; m++)
				for (p = 0; p <= s; p++)
					minmax_tbl[m][p] = COST_INF;
			minmax_tbl[0][0] = 0;
			for (m = 1; m <= n; m++) begin
				top = m < s ? m : s;
				for (p = 1; p <= top; p++) begin
					best = COST_INF;
					for (r = 0; r < m; r++) begin
						c = max64(minmax_tbl[r][p-1], run_sum[m] - run_sum[r]);
						if (c < best)
							best = c;
					end
					minmax_tbl[m][p] = best;
				end
			end
			// Walk back from the last stage, taking the earliest split that matches.
			m = n;
			for (p = s; p >= 1; p--) begin
				target = minmax_tbl[m][p];
				r = 0;
				while (r < m && target != max64(minmax_tbl[r][p-1], run_sum[m] - run_sum[r]))
					r++;
				if (r >= m)
					r = m > 0 ? m - 1 : 0;
				split_at[p-1] = r;
				m = r;
			end
			for (p = 0; p < s; p++) begin
				e.stage = p[3:0];
				e.first = split_at[p][7:0];
				e.cost = minmax_tbl[n][s][40:0];
				e.last = (p + 1 == s);
				e.err = 0;
				outs.insert(outs.size(), e);
			end
		end
		blocks_held = 0;
		dropped_block = 0;
	endfunction

	// Result checker.
	always @(posedge clk) begin
		stage_res_t got, want;
		if (arst_n && result_valid) begin
			got = '{stage: stage_number, first: first_block, cost: bottleneck_cost,
				last: last_stage, err: error_flag};
			if (stage_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %p", got);
			end else begin
				want = stage_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// Watchdog on cycles with no beat moving.
	always @(posedge clk) begin
		if (!arst_n || result_valid || (start && !busy))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("minmax_linear_partition_dp verification failed");
			$finish;
		end
	end

	task automatic write_stages(int unsigned v);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {REG_NUM_STAGES, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		stage_cfg = v & 32'h1f;
	endtask

	// Holds off until every expected result is in and the block has settled.
	task automatic drain;
		@(negedge clk);
		start <= 0;
		while (stage_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_block(logic [31:0] fwd, logic [31:0] bwd, logic fin, int gap,
			bit typed, stage_res_t typed_res);
		stage_res_t outs[$];
		repeat (gap) begin
			@(negedge clk);
			start <= 0;
		end
		@(negedge clk);
		start <= 1;
		forward_cost <= fwd;
		backward_cost <= bwd;
		last_block <= fin;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		partition_block(fwd, bwd, fin, outs);
		if (typed) begin
			if (fin)
				stage_q.insert(stage_q.size(), typed_res);
		end else begin
			foreach (outs[i])
				stage_q.insert(stage_q.size(), outs[i]);
		end
	endtask

	function automatic logic [31:0] rand_cost(int mode);
		case (mode)
			0: return 32'hffff_ffff;
			1: return 32'd0;
			2: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		dir_row_t rows[$];
		stage_res_t err_res, none;
		int items, phase_left, len, gap_max, mode;
		int unsigned cfg;
		bit overflow_done;

		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		start = 0; forward_cost = 0; backward_cost = 0; last_block = 0;
		mismatches = 0; idle_cycles = 0;
		blocks_held = 0; dropped_block = 0; stage_cfg = NUM_STAGES_RESET;
		run_sum[0] = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		err_res = '{stage: 0, first: 0, cost: 0, last: 1, err: 1};
		none = '0;
		// Reset stage count, extremes, each error cause but block overflow, then small real partitions.
		rows.insert(rows.size(), '{-1, 32'd0, 32'd0, 1, 1, '{0, 0, 41'd0, 1, 0}});
		rows.insert(rows.size(), '{-1, 32'hffff_ffff, 32'hffff_ffff, 1, 1,
			'{0, 0, 41'h1_ffff_fffe, 1, 0}});
		rows.insert(rows.size(), '{0, 32'd5, 32'd5, 1, 1, err_res});
		rows.insert(rows.size(), '{31, 32'd1, 32'd2, 1, 1, err_res});
		rows.insert(rows.size(), '{17, 32'd1, 32'd1, 1, 1, err_res});
		rows.insert(rows.size(), '{3, 32'd4, 32'd4, 0, 1, none});
		rows.insert(rows.size(), '{-1, 32'd4, 32'd4, 1, 1, err_res});
		rows.insert(rows.size(), '{-1, 32'd1, 32'd0, 0, 0, none});
		rows.insert(rows.size(), '{-1, 32'd2, 32'd0, 0, 0, none});
		rows.insert(rows.size(), '{-1, 32'd3, 32'd0, 1, 0, none});
		// Equal costs leave ties for the earliest-split rule.
		rows.insert(rows.size(), '{2, 32'd1, 32'd1, 0, 0, none});
		rows.insert(rows.size(), '{-1, 32'd1, 32'd1, 0, 0, none});
		rows.insert(rows.size(), '{-1, 32'd1, 32'd1, 0, 0, none});
		rows.insert(rows.size(), '{-1, 32'd1, 32'd1, 1, 0, none});
		rows.insert(rows.size(), '{16, 32'hffff_ffff, 32'hffff_ffff, 0, 0, none});
		for (int i = 0; i < 14; i++)
			rows.insert(rows.size(), '{-1, 32'hffff_ffff, 32'h0, 0, 0, none});
		rows.insert(rows.size(), '{-1, 32'h0, 32'hffff_ffff, 1, 0, none});

		foreach (rows[i]) begin
			if (rows[i].cfg >= 0) begin
				drain();
				write_stages(rows[i].cfg);
			end
			send_block(rows[i].fwd, rows[i].bwd, rows[i].fin, $urandom_range(0, 6),
				rows[i].typed, rows[i].res);
		end

		items = 0;
		phase_left = 0;
		overflow_done = 0;
		while (items < 170) begin
			if (phase_left == 0) begin
				drain();
				case ($urandom_range(0, 9))
					0: cfg = 0;
					1: cfg = $urandom_range(17, 31);
					2: cfg = 16;
					default: cfg = $urandom_range(1, 15);
				endcase
				write_stages(cfg);
				phase_left = $urandom_range(3, 5);
			end
			if (!overflow_done && items > 60) begin
				// One block past capacity: the whole sequence ends in an error result.
				for (int i = 0; i <= NBLK; i++)
					send_block($urandom, $urandom, i == NBLK, $urandom_range(0, 1), 0, none);
				overflow_done = 1;
			end
			if (stage_cfg == 16 || $urandom_range(0, 6) == 0)
				len = $urandom_range(14, 24);
			else
				len = $urandom_range(1, 10);
			gap_max = $urandom_range(0, 2) == 0 ? 0 : 6;
			mode = $urandom_range(0, 4);
			for (int i = 0; i < len; i++)
				send_block(rand_cost(mode == 4 ? $urandom_range(0, 3) : mode),
					rand_cost($urandom_range(0, 3)), i == len - 1,
					$urandom_range(0, gap_max), 0, none);
			items += len;
			phase_left--;
		end

		drain();
		repeat (50) @(posedge clk);
		if (mismatches == 0 && stage_q.size() == 0)
			$display("minmax_linear_partition_dp verification clean");
		else
			$display("minmax_linear_partition_dp verification failed");
		$finish;
	end

endmodule
